### sv/battery_gauge_averaging_sequencer_top_macros.svh
// Assertion macros for the battery gauge averaging sequencer.
// Included by the top level; needs no package.
`ifndef BATTERY_GAUGE_AVERAGING_SEQUENCER_TOP_MACROS_SVH
`define BATTERY_GAUGE_AVERAGING_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BGAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bgas_pkg.sv
// Package of the battery gauge averaging sequencer: types, widths and constants.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bgas_pkg;

	// Averaging and converter setup.
	localparam int SAMPLE_COUNT = 10;
	localparam int ADC_BITS     = 12;

	// Field and state widths.
	localparam int ADC_W     = 12;
	localparam int TIME_W    = 32;
	localparam int SUM_W     = 16;
	localparam int COUNT_W   = 4;
	localparam int THRESH_W  = 35;
	localparam int PERCENT_W = 8;

	// Configuration port.
	localparam int CFG_DATA_W = 35;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WAIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLT    = 2'd2;

	// Register reset values: 1000 ms, 3.0 V and 4.2 V.
	localparam logic [TIME_W-1:0]   SAMPLE_WAIT_RST = 32'd1000;
	localparam logic [THRESH_W-1:0] MIN_VOLT_RST    = 35'd12884901888;
	localparam logic [THRESH_W-1:0] MAX_VOLT_RST    = 35'd18038862643;

	// Volts per summed code with 32 fractional bits, rounded to nearest.
	localparam longint unsigned VOLT_NUM   = 64'd7445 << (32 - ADC_BITS);
	localparam longint unsigned VOLT_DEN   = 64'd1000 * SAMPLE_COUNT;
	localparam longint unsigned VOLT_SCALE = (VOLT_NUM + VOLT_DEN / 2) / VOLT_DEN;
	localparam int VOLT_SCALE_W = $clog2(VOLT_SCALE + 1);

	// The voltage register is at least as wide as a threshold plus one bit.
	localparam int VOLT_RAW_W = SUM_W + VOLT_SCALE_W;
	localparam int VOLT_W     = (VOLT_RAW_W > THRESH_W) ? VOLT_RAW_W : THRESH_W + 1;

	// Horner evaluation: 64-bit signed accumulator, 32 fractional bits in V.
	localparam int POLY_W       = 64;
	localparam int VOLT_FRAC    = 32;
	localparam int POLY_FRAC    = 16;
	localparam int DIGIT_W      = 16;
	localparam int DIGITS       = POLY_W / DIGIT_W;
	localparam int DIGIT_IDX_W  = $clog2(DIGITS);
	localparam int PROD_W       = POLY_W + VOLT_W;
	localparam int HORNER_TERMS = 5;
	localparam int COEF_IDX_W   = $clog2(HORNER_TERMS);
	localparam int STEP_W       = $clog2(HORNER_TERMS - 1);

	// Quartic coefficients, highest power first, 16 fractional bits.
	localparam logic signed [POLY_W-1:0] HORNER_COEF [0:HORNER_TERMS-1] = '{
		64'sd184050044,
		-64'sd2854808171,
		64'sd16570685116,
		-64'sd42648696357,
		64'sd41060460134
	};

	localparam logic signed [POLY_W-1:0] POLY_MAX = {1'b0, {(POLY_W-1){1'b1}}};
	localparam logic signed [POLY_W-1:0] POLY_MIN = {1'b1, {(POLY_W-1){1'b0}}};

	// Percentages that override the polynomial.
	localparam logic signed [PERCENT_W-1:0] PERCENT_FULL  = 8'sd100;
	localparam logic signed [PERCENT_W-1:0] PERCENT_EMPTY = 8'sd0;
	localparam logic signed [PERCENT_W-1:0] PERCENT_HI    = 8'sd127;
	localparam logic signed [PERCENT_W-1:0] PERCENT_LO    = -8'sd128;

	// Item operation codes.
	typedef enum logic {
		OP_START = 1'b0,
		OP_LOOP  = 1'b1
	} op_t;

	// Gauge phases as seen on the result channel.
	typedef enum logic [1:0] {
		PHASE_IDLE    = 2'd0,
		PHASE_INIT    = 2'd1,
		PHASE_MEASURE = 2'd2,
		PHASE_COMPUTE = 2'd3
	} phase_t;

	// Sequencer states of the controller.
	typedef enum logic [2:0] {
		SQ_READY,
		SQ_VOLT,
		SQ_LOAD,
		SQ_MUL,
		SQ_FIX,
		SQ_ADD,
		SQ_PCT
	} seq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                   clear;
		logic                   take;
		logic                   load_volt;
		logic                   load_mag;
		logic                   mul_digit;
		logic [DIGIT_IDX_W-1:0] digit_idx;
		logic                   fix;
		logic                   add;
		logic [COEF_IDX_W-1:0]  coef_idx;
		logic                   finish;
	} bgas_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic take_ok;
		logic full_next;
	} bgas_status_t;

endpackage

`default_nettype wire

### sv/bgas_datapath.sv
// Datapath of the battery gauge: configuration registers, sample accumulator,
// voltage scaling and the shared multiply unit for Horner evaluation. Uses bgas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgas_datapath (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     cfg_write,
	input  wire  [bgas_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [bgas_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire  [bgas_pkg::TIME_W-1:0]             now_ms,
	input  wire  [bgas_pkg::ADC_W-1:0]              adc_code,
	input  bgas_pkg::bgas_cmd_t                     cmd,
	output bgas_pkg::bgas_status_t                  status,
	output logic signed [bgas_pkg::PERCENT_W-1:0]   battery_percent
);
	import bgas_pkg::*;

	localparam int Q_W = PROD_W - VOLT_FRAC;

	logic [TIME_W-1:0]   sample_wait_q;
	logic [THRESH_W-1:0] min_volt_q;
	logic [THRESH_W-1:0] max_volt_q;
	logic [SUM_W-1:0]    sample_sum_q;
	logic [COUNT_W-1:0]  sample_count_q;
	logic [TIME_W-1:0]   last_sample_q;
	logic signed [PERCENT_W-1:0] percent_q;

	logic [VOLT_W-1:0]        volt_q;
	logic signed [POLY_W-1:0] poly_q;
	logic [POLY_W-1:0]        mag_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        acc_q;

	logic [TIME_W-1:0]             elapsed;
	logic                          take_ok;
	logic [COUNT_W-1:0]            count_next;
	logic [DIGIT_W+VOLT_W-1:0]     digit_prod;
	logic [Q_W-1:0]                quot;
	logic                          rem_nz;
	logic [Q_W:0]                  quot_up;
	logic signed [POLY_W-1:0]      floored;
	logic signed [POLY_W:0]        wide_sum;
	logic signed [POLY_W-1:0]      sat_sum;
	logic signed [POLY_W-POLY_FRAC-1:0] whole;
	logic signed [PERCENT_W-1:0]   percent_d;

	// Configuration writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_wait_q <= SAMPLE_WAIT_RST;
			min_volt_q    <= MIN_VOLT_RST;
			max_volt_q    <= MAX_VOLT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SAMPLE_WAIT: sample_wait_q <= cfg_data[TIME_W-1:0];
				REG_MIN_VOLT:    min_volt_q    <= cfg_data[THRESH_W-1:0];
				REG_MAX_VOLT:    max_volt_q    <= cfg_data[THRESH_W-1:0];
				default:         ;
			endcase
		end
	end

	// A sample is taken when the wrapped time since the last one reaches the wait.
	always_comb begin
		elapsed    = now_ms - last_sample_q;
		take_ok    = (sample_count_q < COUNT_W'(SAMPLE_COUNT)) && (elapsed >= sample_wait_q);
		count_next = sample_count_q + COUNT_W'(take_ok);
		status.take_ok   = take_ok;
		status.full_next = (count_next == COUNT_W'(SAMPLE_COUNT));
	end

	// Accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q   <= '0;
			sample_count_q <= '0;
			last_sample_q  <= '0;
		end else if (cmd.clear) begin
			sample_sum_q   <= '0;
			sample_count_q <= '0;
			last_sample_q  <= '0;
		end else if (cmd.take) begin
			sample_sum_q   <= sample_sum_q + SUM_W'(adc_code);
			sample_count_q <= sample_count_q + COUNT_W'(1);
			last_sample_q  <= now_ms;
		end
	end

	// One 16-bit digit of the magnitude times the voltage.
	assign digit_prod = mag_q[cmd.digit_idx*DIGIT_W +: DIGIT_W] * volt_q;

	// Floor of the signed product over 2^32, saturated to 64 bits.
	always_comb begin
		quot    = acc_q[PROD_W-1:VOLT_FRAC];
		rem_nz  = |acc_q[VOLT_FRAC-1:0];
		quot_up = {1'b0, quot} + (Q_W+1)'(rem_nz);
		if (!neg_q) begin
			if (|quot[Q_W-1:POLY_W-1]) begin
				floored = POLY_MAX;
			end else begin
				floored = $signed(quot[POLY_W-1:0]);
			end
		end else begin
			if (|quot_up[Q_W:POLY_W-1]) begin
				floored = POLY_MIN;
			end else begin
				floored = -$signed(quot_up[POLY_W-1:0]);
			end
		end
	end

	// Saturating add of the next coefficient.
	always_comb begin
		wide_sum = {poly_q[POLY_W-1], poly_q}
			+ {HORNER_COEF[cmd.coef_idx][POLY_W-1], HORNER_COEF[cmd.coef_idx]};
		if (wide_sum[POLY_W] != wide_sum[POLY_W-1]) begin
			sat_sum = wide_sum[POLY_W] ? POLY_MIN : POLY_MAX;
		end else begin
			sat_sum = wide_sum[POLY_W-1:0];
		end
	end

	// Whole percent truncated toward zero, clamped, then threshold overrides.
	always_comb begin
		whole = poly_q[POLY_W-1:POLY_FRAC];
		if (poly_q[POLY_W-1] && (|poly_q[POLY_FRAC-1:0])) begin
			whole = whole + (POLY_W-POLY_FRAC)'(1);
		end
		if (whole > (POLY_W-POLY_FRAC)'(signed'(PERCENT_HI))) begin
			percent_d = PERCENT_HI;
		end else if (whole < (POLY_W-POLY_FRAC)'(signed'(PERCENT_LO))) begin
			percent_d = PERCENT_LO;
		end else begin
			percent_d = whole[PERCENT_W-1:0];
		end
		if (volt_q > VOLT_W'(max_volt_q)) begin
			percent_d = PERCENT_FULL;
		end else if (volt_q < VOLT_W'(min_volt_q)) begin
			percent_d = PERCENT_EMPTY;
		end
	end

	// Horner working registers.
	always_ff @(posedge clk) begin
		if (cmd.load_volt) begin
			volt_q <= VOLT_W'(sample_sum_q) * VOLT_W'(VOLT_SCALE);
			poly_q <= HORNER_COEF[0];
		end
		if (cmd.load_mag) begin
			neg_q <= poly_q[POLY_W-1];
			mag_q <= poly_q[POLY_W-1] ? POLY_W'(-poly_q) : POLY_W'(poly_q);
			acc_q <= '0;
		end
		if (cmd.mul_digit) begin
			acc_q <= (acc_q << DIGIT_W) + PROD_W'(digit_prod);
		end
		if (cmd.fix) begin
			poly_q <= floored;
		end
		if (cmd.add) begin
			poly_q <= sat_sum;
		end
	end

	// Last computed percentage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_q <= '0;
		end else if (cmd.finish) begin
			percent_q <= percent_d;
		end
	end

	assign battery_percent = percent_q;

endmodule

`default_nettype wire

### sv/bgas_ctrl.sv
// Controller of the battery gauge: gauge phase, Horner sequencer and result register.
// Drives the datapath through bgas_cmd_t; uses bgas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgas_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire                    operation,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   start_accepted,
	output bgas_pkg::phase_t       phase,
	output logic                   result_ready,
	input  bgas_pkg::bgas_status_t status,
	output bgas_pkg::bgas_cmd_t    cmd
);
	import bgas_pkg::*;

	seq_state_t              state_q, state_d;
	phase_t                  phase_q, phase_d;
	logic [DIGIT_IDX_W-1:0]  digit_q, digit_d;
	logic [STEP_W-1:0]       step_q, step_d;
	logic                    out_valid_q, out_valid_d;
	logic                    start_acc_q, start_acc_d;
	logic                    ready_q, ready_d;
	logic                    accept;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_READY;
			phase_q     <= PHASE_IDLE;
			digit_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			start_acc_q <= 1'b0;
			ready_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			digit_q     <= digit_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
			start_acc_q <= start_acc_d;
			ready_q     <= ready_d;
		end
	end

	// Input is taken only when the sequencer is free and the result slot drains.
	assign in_stall = (state_q != SQ_READY) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// Next state, datapath commands and result register.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		digit_d     = digit_q;
		step_d      = step_q;
		start_acc_d = start_acc_q;
		ready_d     = ready_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.digit_idx = digit_q;
		cmd.coef_idx  = COEF_IDX_W'(step_q) + COEF_IDX_W'(1);

		case (state_q)
			SQ_READY: begin
				if (accept) begin
					out_valid_d = 1'b1;
					start_acc_d = 1'b0;
					ready_d     = 1'b0;
					case (op_t'(operation))
						OP_START: begin
							if (phase_q == PHASE_IDLE) begin
								phase_d     = PHASE_INIT;
								start_acc_d = 1'b1;
							end
						end
						OP_LOOP: begin
							case (phase_q)
								PHASE_INIT: begin
									cmd.clear = 1'b1;
									phase_d   = PHASE_MEASURE;
								end
								PHASE_MEASURE: begin
									cmd.take = status.take_ok;
									if (status.full_next) begin
										phase_d = PHASE_COMPUTE;
									end
								end
								PHASE_COMPUTE: begin
									out_valid_d = 1'b0;
									state_d     = SQ_VOLT;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			SQ_VOLT: begin
				cmd.load_volt = 1'b1;
				step_d        = '0;
				state_d       = SQ_LOAD;
			end
			SQ_LOAD: begin
				cmd.load_mag = 1'b1;
				digit_d      = DIGIT_IDX_W'(DIGITS - 1);
				state_d      = SQ_MUL;
			end
			SQ_MUL: begin
				cmd.mul_digit = 1'b1;
				digit_d       = digit_q - DIGIT_IDX_W'(1);
				if (digit_q == '0) begin
					state_d = SQ_FIX;
				end
			end
			SQ_FIX: begin
				cmd.fix = 1'b1;
				state_d = SQ_ADD;
			end
			SQ_ADD: begin
				cmd.add = 1'b1;
				step_d  = step_q + STEP_W'(1);
				if (step_q == STEP_W'(HORNER_TERMS - 2)) begin
					state_d = SQ_PCT;
				end else begin
					state_d = SQ_LOAD;
				end
			end
			SQ_PCT: begin
				cmd.finish  = 1'b1;
				phase_d     = PHASE_IDLE;
				out_valid_d = 1'b1;
				start_acc_d = 1'b0;
				ready_d     = 1'b1;
				state_d     = SQ_READY;
			end
			default: begin
				state_d = SQ_READY;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign start_accepted = start_acc_q;
	assign phase          = phase_q;
	assign result_ready   = ready_q;

endmodule

`default_nettype wire

### sv/battery_gauge_averaging_sequencer_top.sv
// Top level of the battery gauge averaging sequencer: controller plus datapath.
// Depends on bgas_pkg, bgas_ctrl, bgas_datapath and the assertion macro header.
//
//   channel   direction   handshake              payload
//   input     in          in_valid / in_stall    operation, now_ms, adc_code
//   result    out         out_valid / out_stall  battery_percent, start_accepted,
//                                                phase, result_ready
//   config    in          cfg_write              cfg_index, cfg_data
//
// The result of every item but a compute pass is registered at the edge that accepts it.
// A compute item passes through the voltage product, four Horner steps (magnitude load,
// four 16-bit digit products, floor, add) and the percentage; its result is registered
// as the sequencer leaves the percentage state.
// The single shared digit multiplier takes the digit products one after another.
// in_stall is high while a computation runs and while an unread result is stalled.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_gauge_averaging_sequencer_top_macros.svh"

module battery_gauge_averaging_sequencer_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire                                    operation,
	input  wire  [bgas_pkg::TIME_W-1:0]            now_ms,
	input  wire  [bgas_pkg::ADC_W-1:0]             adc_code,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic signed [bgas_pkg::PERCENT_W-1:0]  battery_percent,
	output logic                                   start_accepted,
	output logic [1:0]                             phase,
	output logic                                   result_ready,
	input  wire                                    cfg_write,
	input  wire  [bgas_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [bgas_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import bgas_pkg::*;

	bgas_cmd_t    cmd;
	bgas_status_t status;
	phase_t       ctl_phase;

	// Phase sequencing and Horner control.
	bgas_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.start_accepted (start_accepted),
		.phase          (ctl_phase),
		.result_ready   (result_ready),
		.status         (status),
		.cmd            (cmd)
	);

	// Registers, accumulator and arithmetic.
	bgas_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.now_ms          (now_ms),
		.adc_code        (adc_code),
		.cmd             (cmd),
		.status          (status),
		.battery_percent (battery_percent)
	);

	assign phase = ctl_phase;

	// A finished computation always leaves the gauge idle.
	`BGAS_ASSERT_NOW(a_ready_idle, clk, arst_n, out_valid && result_ready, (ctl_phase == PHASE_IDLE) && !start_accepted, "result_ready without idle phase")

	// An accepted start always moves the gauge to init.
	`BGAS_ASSERT_NOW(a_start_init, clk, arst_n, out_valid && start_accepted, ctl_phase == PHASE_INIT, "start accepted without init phase")

	// After an accepted item either its result waits or the block is busy.
	`BGAS_ASSERT_NEXT(a_accept_tracked, clk, arst_n, in_valid && !in_stall, out_valid || in_stall, "accepted item lost")

endmodule

`default_nettype wire
